@@ sv/sorted_wakeup_timer_queue_top_defines.svh @@
// ---------------------------------------------------------------------------
// sorted wakeup timer queue - assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SORTED_WAKEUP_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define SWTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define SWTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/swtq_pkg.sv @@
// ---------------------------------------------------------------------------
// swtq_pkg
// types, codes and defaults shared by the timer queue modules
// ---------------------------------------------------------------------------
`default_nettype none

package swtq_pkg;

	localparam int ID_W    = 8;
	localparam int STAMP_W = 64;

	localparam int DEFAULT_QUEUE_DEPTH = 64;
	localparam int DEFAULT_WAKE_BATCH  = 64;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [1:0] OUTCOME_ACCEPTED = 2'd0;
	localparam logic [1:0] OUTCOME_REJECTED = 2'd1;
	localparam logic [1:0] OUTCOME_WOKEN    = 2'd2;

	typedef struct packed {
		logic               command;
		logic [ID_W-1:0]    task_id;
		logic [STAMP_W-1:0] wake_stamp;
		logic [STAMP_W-1:0] now_stamp;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      outcome;
		logic [ID_W-1:0] woken_id;
		logic            final_of_run;
	} out_item_t;

	// one stored queue entry
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [ID_W-1:0]    id;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic ins_init;
		logic ins_read;
		logic ins_shift;
		logic ins_place;
		logic emit_result;
		logic tick_init;
		logic tick_pop;
		logic emit_pend;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_tick;
		logic full;
		logic empty;
		logic rem_one;
		logic later;
		logic qualify;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/swtq_ram.sv @@
// ---------------------------------------------------------------------------
// swtq_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module swtq_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/swtq_ctrl.sv @@
// ---------------------------------------------------------------------------
// swtq_ctrl
// sequencer for insert and tick handling
// ---------------------------------------------------------------------------
`default_nettype none

module swtq_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire swtq_pkg::dp_status_t  status,
	output swtq_pkg::ctrl_cmd_t        ctrl
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INS_RD  = 3'd1;
	localparam logic [2:0] ST_INS_CMP = 3'd2;
	localparam logic [2:0] ST_INS_PUT = 3'd3;
	localparam logic [2:0] ST_RESULT  = 3'd4;
	localparam logic [2:0] ST_TK_RD   = 3'd5;
	localparam logic [2:0] ST_TK_CMP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign cmd_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctrl.load_item = 1'b1;
					if (status.in_tick) begin
						state_d = ST_TK_RD;
					end else if (status.full) begin
						state_d = ST_RESULT;
					end else begin
						ctrl.ins_init = 1'b1;
						state_d = status.empty ? ST_INS_PUT : ST_INS_RD;
					end
				end
			end
			ST_INS_RD: begin
				ctrl.ins_read = 1'b1;
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				// later stamps move up one slot, the new entry lands just ahead of them
				if (status.later) begin
					ctrl.ins_shift = 1'b1;
					if (status.rem_one) begin
						state_d = ST_INS_PUT;
					end
				end else begin
					ctrl.ins_place = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_INS_PUT: begin
				ctrl.ins_place = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					ctrl.emit_result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TK_RD: begin
				ctrl.tick_init = 1'b1;
				state_d = ST_TK_CMP;
			end
			ST_TK_CMP: begin
				// a held wake-up goes out once the next head is judged
				if (!status.pend_valid || status.out_free) begin
					ctrl.emit_pend = status.pend_valid;
					if (status.qualify) begin
						ctrl.tick_pop = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/swtq_dpath.sv @@
// ---------------------------------------------------------------------------
// swtq_dpath
// circular entry store, pointers, comparators and result register
// ---------------------------------------------------------------------------
`default_nettype none

module swtq_dpath #(
	parameter int QUEUE_DEPTH = swtq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int WAKE_BATCH  = swtq_pkg::DEFAULT_WAKE_BATCH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swtq_pkg::in_item_t   cmd_data,
	input  wire logic                 res_stall,
	output logic                      res_valid,
	output swtq_pkg::out_item_t       res_data,
	input  wire swtq_pkg::ctrl_cmd_t  ctrl,
	output swtq_pkg::dp_status_t      status
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = $clog2(WAKE_BATCH + 1);
	localparam int EW = $bits(swtq_pkg::entry_t);
	localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [TW-1:0] BATCH_LIM = TW'(WAKE_BATCH);

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		return (p == '0) ? LAST_ADDR : p - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + AW'(1);
	endfunction

	swtq_pkg::in_item_t item_q;
	logic               reject_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      rem_q;
	logic [TW-1:0]      taken_q;
	logic               pend_valid_q;
	logic [swtq_pkg::ID_W-1:0] pend_id_q;
	logic               res_valid_q;
	swtq_pkg::out_item_t res_data_q;

	logic [AW:0]        tail_sum;
	logic [AW-1:0]      tail;
	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [EW-1:0]      ram_wr_data;
	logic               ram_rd_en;
	logic [AW-1:0]      ram_rd_addr;
	logic [EW-1:0]      ram_rd_data;
	swtq_pkg::entry_t   rd_entry;
	swtq_pkg::entry_t   new_entry;
	logic               out_free;
	logic               qualify;

	// first free slot behind the last stored entry
	assign tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
	always_comb begin
		if (tail_sum >= DEPTH_EXT) begin
			tail = AW'(tail_sum - DEPTH_EXT);
		end else begin
			tail = tail_sum[AW-1:0];
		end
	end

	assign rd_entry        = swtq_pkg::entry_t'(ram_rd_data);
	assign new_entry.stamp = item_q.wake_stamp;
	assign new_entry.id    = item_q.task_id;
	assign out_free        = !res_valid_q || !res_stall;
	assign qualify         = (taken_q != BATCH_LIM) && (count_q != '0)
	                         && (rd_entry.stamp <= item_q.now_stamp);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = pos_q;
		ram_wr_data = new_entry;
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		if (ctrl.ins_read) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = ptr_prev(pos_q);
		end
		if (ctrl.ins_shift) begin
			ram_wr_en   = 1'b1;
			ram_wr_data = ram_rd_data;
			ram_rd_en   = 1'b1;
			ram_rd_addr = ptr_prev(rd_ptr_q);
		end
		if (ctrl.ins_place) begin
			ram_wr_en = 1'b1;
		end
		if (ctrl.tick_init) begin
			ram_rd_en = 1'b1;
		end
		if (ctrl.tick_pop) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = ptr_next(head_q);
		end
	end

	swtq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// item and walk registers
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			item_q   <= cmd_data;
			reject_q <= (count_q == FULL_CNT);
		end
		if (ctrl.ins_init) begin
			pos_q <= tail;
			rem_q <= count_q;
		end
		if (ctrl.ins_read) begin
			rd_ptr_q <= ptr_prev(pos_q);
		end
		if (ctrl.ins_shift) begin
			pos_q    <= rd_ptr_q;
			rd_ptr_q <= ptr_prev(rd_ptr_q);
			rem_q    <= rem_q - CW'(1);
		end
		if (ctrl.tick_pop) begin
			pend_id_q <= rd_entry.id;
		end
		if (ctrl.emit_result) begin
			res_data_q.outcome      <= reject_q ? swtq_pkg::OUTCOME_REJECTED
			                                    : swtq_pkg::OUTCOME_ACCEPTED;
			res_data_q.woken_id     <= item_q.task_id;
			res_data_q.final_of_run <= 1'b1;
		end else if (ctrl.emit_pend) begin
			res_data_q.outcome      <= swtq_pkg::OUTCOME_WOKEN;
			res_data_q.woken_id     <= pend_id_q;
			res_data_q.final_of_run <= !qualify;
		end
	end

	// queue occupancy and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			taken_q      <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (ctrl.ins_place) begin
				count_q <= count_q + CW'(1);
			end
			if (ctrl.tick_init) begin
				taken_q <= '0;
			end
			if (ctrl.tick_pop) begin
				head_q  <= ptr_next(head_q);
				count_q <= count_q - CW'(1);
				taken_q <= taken_q + TW'(1);
			end
			if (ctrl.tick_pop) begin
				pend_valid_q <= 1'b1;
			end else if (ctrl.emit_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (ctrl.emit_result || ctrl.emit_pend) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	assign status.in_tick    = (cmd_data.command == swtq_pkg::CMD_TICK);
	assign status.full       = (count_q == FULL_CNT);
	assign status.empty      = (count_q == '0);
	assign status.rem_one    = (rem_q == CW'(1));
	assign status.later      = (rd_entry.stamp > item_q.wake_stamp);
	assign status.qualify    = qualify;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

endmodule

`default_nettype wire

@@ sv/sorted_wakeup_timer_queue_top.sv @@
// ---------------------------------------------------------------------------
// sorted_wakeup_timer_queue_top
// wake-up timer queue kept in stamp order, with batched expiry on ticks
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   cmd      | in        | cmd_valid, cmd_stall | in_item_t  (insert / tick)
//   res      | out       | res_valid, res_stall | out_item_t (one per result)
//
// an insert walks back from the tail, one ram read and write a cycle,
//   shifting each stored entry with a later stamp up one slot
// a tick wakes tasks from the head, one ram read per head entry
// a full-queue insert goes straight to the result state for its rejection
// reset clears count, head pointer, batch tally and handshake flags only; no clearing pass
// a stalled result holds the sequencer only when the next result is ready
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_timer_queue_top #(
	parameter int QUEUE_DEPTH = swtq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int WAKE_BATCH  = swtq_pkg::DEFAULT_WAKE_BATCH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire swtq_pkg::in_item_t  cmd_data,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output swtq_pkg::out_item_t      res_data
);

	// command and status between sequencer and datapath
	swtq_pkg::ctrl_cmd_t  ctrl;
	swtq_pkg::dp_status_t status;

	// the sequencer takes one command item at a time, only from idle
	swtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.status    (status),
		.ctrl      (ctrl)
	);

	// entries live in a circular ram: head is the earliest stamp,
	// inserts shuffle later stamps up from the tail, ticks pop the head
	swtq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WAKE_BATCH  (WAKE_BATCH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_data  (res_data),
		.ctrl      (ctrl),
		.status    (status)
	);

endmodule

`default_nettype wire

@@ sv/swtq_checker.sv @@
// ---------------------------------------------------------------------------
// swtq_checker
// port-level checks on the timer queue, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_wakeup_timer_queue_top_defines.svh"

module swtq_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_stall,
	input wire swtq_pkg::in_item_t  cmd_data,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire swtq_pkg::out_item_t res_data
);

	logic cmd_xfer;
	logic res_held;
	logic res_insert;
	logic code_known;

	assign cmd_xfer   = cmd_valid && !cmd_stall;
	assign res_held   = res_valid && res_stall;
	assign res_insert = res_valid && (res_data.outcome != swtq_pkg::OUTCOME_WOKEN);
	assign code_known = res_data.outcome inside {swtq_pkg::OUTCOME_ACCEPTED,
		swtq_pkg::OUTCOME_REJECTED, swtq_pkg::OUTCOME_WOKEN};

	// a command transfer always leaves the queue busy, with cmd_stall raised
	`SWTQ_ASSERT_NEXT(a_busy, clk, arst_n, cmd_xfer, cmd_stall, "idle after transfer")

	// insert outcomes are single results and so always close the run
	`SWTQ_ASSERT_NOW(a_final, clk, arst_n, res_insert, res_data.final_of_run, "not final")

	// only the three defined outcome codes appear
	`SWTQ_ASSERT_NOW(a_outcome_code, clk, arst_n, res_valid, code_known, "bad outcome code")

	// a stalled result holds
	`SWTQ_ASSERT_NEXT(a_hold_valid, clk, arst_n, res_held, res_valid, "held result dropped")
	`SWTQ_ASSERT_NEXT(a_hold_data, clk, arst_n, res_held, $stable(res_data), "held data moved")

endmodule

bind sorted_wakeup_timer_queue_top swtq_checker u_swtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_data  (cmd_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire
